FILE: design/gn3d_pkg.sv
package gn3d_pkg;

   // defaults for the top-level parameters
   localparam int TABLE_SIZE_DEF = 256;
   localparam int FRAC_BITS_DEF  = 16;

   // field widths of the request and response words
   localparam int INDEX_W    = 8;
   localparam int PERM_W     = 8;
   localparam int GRAD_W     = 16;
   localparam int POINT_W    = 32;
   localparam int NOISE_W    = 18;
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 24;

   // saturation limits of the Q1.16 result
   localparam int NOISE_MAX = 131071;
   localparam int NOISE_MIN = -131072;

   // action codes carried in req_tuser
   localparam logic [1:0] ACT_LOAD_PERM = 2'd0;
   localparam logic [1:0] ACT_LOAD_GRAD = 2'd1;
   localparam logic [1:0] ACT_EVAL      = 2'd2;
   localparam logic [1:0] ACT_UNUSED    = 2'd3;

endpackage

FILE: design/gn3d_ram.sv
module gn3d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: design/gradient_noise_3d.sv
// Classic 3D gradient noise, one word accepted per clock while the response
// side does not stall. A "load permutation" or "load gradient" word writes
// one table entry and, like a word with the unused action, is answered by a
// zero word with rsp_tuser low; an evaluate word carries a Q15.16 point and
// is answered by the saturated Q1.16 noise value with rsp_tuser high. The
// pipeline has twelve register stages, the response register included (two
// permutation lookups, a gradient lookup, the dot products and three rounds
// of interpolation). Back-pressure on the response side stalls the whole
// pipeline without loss. Tables must be loaded
// before evaluation reads them; the permutation table is kept in three copies
// and the gradient table in four, each copy written by the load word as it
// passes the stage where that copy is read.
module gradient_noise_3d #(
   parameter int TABLE_SIZE = gn3d_pkg::TABLE_SIZE_DEF,
   parameter int FRAC_BITS  = gn3d_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // table_index[7:0], perm_entry[15:8], grad_x[31:16], grad_y[47:32],
   // grad_z[63:48], point_x[95:64], point_y[127:96], point_z[159:128]
   input  logic [gn3d_pkg::REQ_DATA_W-1:0]    req_tdata,
   // action[1:0]
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // noise_value[17:0], zero fill above
   output logic [gn3d_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // is_noise[0]
   output logic [0:0]                         rsp_tuser
);
   import gn3d_pkg::*;

   localparam int IW  = $clog2(TABLE_SIZE);
   localparam int F   = FRAC_BITS;
   localparam int RW  = F + 2;              // corner offset
   localparam int PW  = GRAD_W + RW;        // gradient times offset
   localparam int DW  = F + 5;              // dot products and blends
   localparam int SW  = F + 1;              // smoothstep weight
   localparam int MW  = F + 2;              // 3 - 2f
   localparam int TW  = F + MW;             // t2 * (3 - 2f)
   localparam int BW  = DW + SW + 2;        // blend product
   localparam int OW  = DW + 10;            // output conversion
   localparam int DN  = (F > 16) ? F - 16 : 0;
   localparam int UP  = (F < 16) ? 16 - F : 0;
   localparam int RND = (1 << DN) >> 1;

   // ---------------------------------------------------------------- helpers
   function automatic logic [IW-1:0] idx_of(input logic [INDEX_W-1:0] i);
      logic [IW+INDEX_W-1:0] e;
      e = (IW + INDEX_W)'(i);
      return e[IW-1:0];
   endfunction

   // floor(p / 2^F) wrapped to the table size
   function automatic logic [IW-1:0] cell_of(input logic [POINT_W-1:0] p);
      logic [POINT_W+IW-1:0] e;
      e = {{IW{p[POINT_W-1]}}, p};
      return e[F+IW-1:F];
   endfunction

   function automatic logic [IW-1:0] hash(input logic [PERM_W-1:0] b,
                                          input logic [IW-1:0] c);
      logic [IW+PERM_W-1:0] s;
      s = (IW + PERM_W)'(b) + (IW + PERM_W)'(c);
      return s[IW-1:0];
   endfunction

   function automatic logic signed [BW-1:0] bl_mul(input logic [SW-1:0] s,
                                                   input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
      logic signed [DW:0] d;
      logic signed [SW:0] w;
      d = (DW + 1)'(b) - (DW + 1)'(a);
      w = $signed({1'b0, s});
      return d * w;
   endfunction

   function automatic logic signed [DW-1:0] bl_add(input logic signed [DW-1:0] a,
                                                   input logic signed [BW-1:0] p);
      logic signed [BW:0] r;
      r = ((BW + 1)'(p) + (BW + 1)'(1 << (F - 1))) >>> F;
      r = (BW + 1)'(a) + r;
      return r[DW-1:0];
   endfunction

   function automatic logic [NOISE_W-1:0] to_out(input logic signed [DW-1:0] v);
      logic signed [OW-1:0] w;
      w = (OW'(v) + OW'(RND)) >>> DN;
      w = w <<< UP;
      if (w > OW'(NOISE_MAX)) begin
         w = OW'(NOISE_MAX);
      end else if (w < OW'(NOISE_MIN)) begin
         w = OW'(NOISE_MIN);
      end
      return w[NOISE_W-1:0];
   endfunction

   // ---------------------------------------------------------------- control
   logic en;
   logic acc;
   logic              vld_ff [1:11];
   logic              evl_ff [3:11];
   logic              rsp_vld_ff;
   logic [NOISE_W-1:0] rsp_noise_ff;
   logic              rsp_user_ff;

   assign en         = !rsp_vld_ff || rsp_tready;
   assign acc        = req_tvalid && en;
   assign req_tready = en;

   // ---------------------------------------------------------------- stage 0
   logic [INDEX_W-1:0]       in_idx;
   logic [PERM_W-1:0]        in_perm;
   logic [3*GRAD_W-1:0]      in_grad;
   logic [POINT_W-1:0]       in_pt [3];
   logic [IW-1:0]            cx0;
   logic [IW-1:0]            cx1;
   logic [PERM_W-1:0]        pi_a;
   logic [PERM_W-1:0]        pi_b;

   assign in_idx   = req_tdata[7:0];
   assign in_perm  = req_tdata[15:8];
   assign in_grad  = req_tdata[63:16];
   assign in_pt[0] = req_tdata[95:64];
   assign in_pt[1] = req_tdata[127:96];
   assign in_pt[2] = req_tdata[159:128];
   assign cx0      = cell_of(in_pt[0]);
   assign cx1      = cx0 + IW'(1);

   // first permutation lookup, on the x cells
   gn3d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_a (
      .clock     (clock),
      .wr_en     (acc && req_tuser == ACT_LOAD_PERM),
      .wr_addr   (idx_of(in_idx)),
      .wr_data   (in_perm),
      .rd_en     (en),
      .rd_addr_a (cx0),
      .rd_addr_b (cx1),
      .rd_data_a (pi_a),
      .rd_data_b (pi_b)
   );

   // ---------------------------------------------------------------- stage 1
   logic [1:0]          act1_ff;
   logic [IW-1:0]       idx1_ff;
   logic [PERM_W-1:0]   perm1_ff;
   logic [3*GRAD_W-1:0] grad1_ff;
   logic [IW-1:0]       cy1_ff [2];
   logic [IW-1:0]       cz1_ff [2];
   logic [F-1:0]        f1_ff [3];
   logic [2*F-1:0]      sq1 [3];
   logic [PERM_W-1:0]   bv [4];

   always_ff @(posedge clock) begin
      if (en) begin
         act1_ff   <= req_tuser;
         idx1_ff   <= idx_of(in_idx);
         perm1_ff  <= in_perm;
         grad1_ff  <= in_grad;
         cy1_ff[0] <= cell_of(in_pt[1]);
         cy1_ff[1] <= cell_of(in_pt[1]) + IW'(1);
         cz1_ff[0] <= cell_of(in_pt[2]);
         cz1_ff[1] <= cell_of(in_pt[2]) + IW'(1);
         for (int c = 0; c < 3; c++) begin
            f1_ff[c] <= in_pt[c][F-1:0];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sq1[c] = (2 * F)'(f1_ff[c]) * (2 * F)'(f1_ff[c]);
      end
   end

   // second permutation lookup, two copies for the four x/y pairs
   for (genvar g = 0; g < 2; g++) begin : g_perm_b
      gn3d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_b (
         .clock     (clock),
         .wr_en     (en && vld_ff[1] && act1_ff == ACT_LOAD_PERM),
         .wr_addr   (idx1_ff),
         .wr_data   (perm1_ff),
         .rd_en     (en),
         .rd_addr_a (hash(pi_a, cy1_ff[g])),
         .rd_addr_b (hash(pi_b, cy1_ff[g])),
         .rd_data_a (bv[2*g]),
         .rd_data_b (bv[2*g+1])
      );
   end

   // ---------------------------------------------------------------- stage 2
   logic [1:0]          act2_ff;
   logic [IW-1:0]       idx2_ff;
   logic [3*GRAD_W-1:0] grad2_ff;
   logic [IW-1:0]       cz2_ff [2];
   logic [F-1:0]        f2_ff [3];
   logic [2*F-1:0]      sq2_ff [3];
   logic [F-1:0]        t2c [3];
   logic [3*GRAD_W-1:0] gv [8];

   always_ff @(posedge clock) begin
      if (en) begin
         act2_ff  <= act1_ff;
         idx2_ff  <= idx1_ff;
         grad2_ff <= grad1_ff;
         cz2_ff   <= cz1_ff;
         f2_ff    <= f1_ff;
         sq2_ff   <= sq1;
      end
   end

   // smoothstep, first rounding: t2 = round(f*f / 2^F)
   always_comb begin
      logic [2*F:0] r;
      for (int c = 0; c < 3; c++) begin
         r      = (2 * F + 1)'(sq2_ff[c]) + (2 * F + 1)'(1 << (F - 1));
         t2c[c] = r[2*F-1:F];
      end
   end

   // gradient lookup, four copies for the eight corners
   for (genvar g = 0; g < 4; g++) begin : g_grad
      gn3d_ram #(.WIDTH(3 * GRAD_W), .DEPTH(TABLE_SIZE)) u_grad (
         .clock     (clock),
         .wr_en     (en && vld_ff[2] && act2_ff == ACT_LOAD_GRAD),
         .wr_addr   (idx2_ff),
         .wr_data   (grad2_ff),
         .rd_en     (en),
         .rd_addr_a (hash(bv[(2*g) % 4], cz2_ff[g/2])),
         .rd_addr_b (hash(bv[(2*g+1) % 4], cz2_ff[g/2])),
         .rd_data_a (gv[2*g]),
         .rd_data_b (gv[2*g+1])
      );
   end

   // ---------------------------------------------------------------- stage 3
   logic [F-1:0]          f3_ff [3];
   logic [F-1:0]          t23_ff [3];
   logic signed [PW-1:0]  pr3 [8][3];
   logic [TW-1:0]         tp3 [3];

   always_ff @(posedge clock) begin
      if (en) begin
         f3_ff  <= f2_ff;
         t23_ff <= t2c;
      end
   end

   // gradient component times corner offset, 24 products
   always_comb begin
      logic signed [GRAD_W-1:0] gc;
      logic signed [RW-1:0]     rc;
      logic [MW-1:0]            m;
      for (int k = 0; k < 8; k++) begin
         for (int c = 0; c < 3; c++) begin
            gc = gv[k][GRAD_W*c +: GRAD_W];
            rc = ((k >> c) & 1) != 0 ? $signed({2'b11, f3_ff[c]})
                                     : $signed({2'b00, f3_ff[c]});
            pr3[k][c] = gc * rc;
         end
      end
      for (int c = 0; c < 3; c++) begin
         m      = MW'(3 * (1 << F)) - MW'({f3_ff[c], 1'b0});
         tp3[c] = TW'(t23_ff[c]) * TW'(m);
      end
   end

   // ---------------------------------------------------------------- stage 4
   logic signed [PW-1:0] pr4_ff [8][3];
   logic [TW-1:0]        tp4_ff [3];
   logic signed [DW-1:0] dot4 [8];
   logic [SW-1:0]        s4 [3];

   always_ff @(posedge clock) begin
      if (en) begin
         pr4_ff <= pr3;
         tp4_ff <= tp3;
      end
   end

   // dot products rounded to Q.F, smoothstep second rounding
   always_comb begin
      logic signed [PW+1:0] sm;
      logic [TW:0]          r;
      for (int k = 0; k < 8; k++) begin
         sm = (PW + 2)'(pr4_ff[k][0]) + (PW + 2)'(pr4_ff[k][1])
            + (PW + 2)'(pr4_ff[k][2]) + (PW + 2)'(1 << 13);
         sm = sm >>> 14;
         dot4[k] = sm[DW-1:0];
      end
      for (int c = 0; c < 3; c++) begin
         r     = (TW + 1)'(tp4_ff[c]) + (TW + 1)'(1 << (F - 1));
         s4[c] = r[F+SW-1:F];
      end
   end

   // ---------------------------------------------------------------- stage 5
   logic signed [DW-1:0] dot5_ff [8];
   logic [SW-1:0]        s5_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         dot5_ff <= dot4;
         s5_ff   <= s4;
      end
   end

   // ---------------------------------------------------------- stages 6 to 7
   logic signed [BW-1:0] xp6_ff [4];
   logic signed [DW-1:0] xa6_ff [4];
   logic [SW-1:0]        sy6_ff;
   logic [SW-1:0]        sz6_ff;
   logic signed [DW-1:0] lx7_ff [4];
   logic [SW-1:0]        sy7_ff;
   logic [SW-1:0]        sz7_ff;

   // blend along x
   always_ff @(posedge clock) begin
      if (en) begin
         for (int m = 0; m < 4; m++) begin
            xp6_ff[m] <= bl_mul(s5_ff[0], dot5_ff[2*m], dot5_ff[2*m+1]);
            xa6_ff[m] <= dot5_ff[2*m];
            lx7_ff[m] <= bl_add(xa6_ff[m], xp6_ff[m]);
         end
         sy6_ff <= s5_ff[1];
         sz6_ff <= s5_ff[2];
         sy7_ff <= sy6_ff;
         sz7_ff <= sz6_ff;
      end
   end

   // --------------------------------------------------------- stages 8 to 11
   logic signed [BW-1:0] yp8_ff [2];
   logic signed [DW-1:0] ya8_ff [2];
   logic [SW-1:0]        sz8_ff;
   logic signed [DW-1:0] ly9_ff [2];
   logic [SW-1:0]        sz9_ff;
   logic signed [BW-1:0] zp10_ff;
   logic signed [DW-1:0] za10_ff;
   logic signed [DW-1:0] val11_ff;

   // blend along y, then along z
   always_ff @(posedge clock) begin
      if (en) begin
         for (int n = 0; n < 2; n++) begin
            yp8_ff[n] <= bl_mul(sy7_ff, lx7_ff[2*n], lx7_ff[2*n+1]);
            ya8_ff[n] <= lx7_ff[2*n];
            ly9_ff[n] <= bl_add(ya8_ff[n], yp8_ff[n]);
         end
         sz8_ff   <= sz7_ff;
         sz9_ff   <= sz8_ff;
         zp10_ff  <= bl_mul(sz9_ff, ly9_ff[0], ly9_ff[1]);
         za10_ff  <= ly9_ff[0];
         val11_ff <= bl_add(za10_ff, zp10_ff);
      end
   end

   // ------------------------------------------------------- response register
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_noise_ff <= evl_ff[11] ? to_out(val11_ff) : '0;
         rsp_user_ff  <= evl_ff[11];
      end
   end

   // valid bits and the evaluate flag travel with the word
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= 11; s++) begin
            vld_ff[s] <= 1'b0;
         end
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff[1] <= req_tvalid;
         for (int s = 2; s <= 11; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         rsp_vld_ff <= vld_ff[11];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         evl_ff[3] <= vld_ff[2] && act2_ff == ACT_EVAL;
         for (int s = 4; s <= 11; s++) begin
            evl_ff[s] <= evl_ff[s-1];
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_noise_ff);
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import gn3d_pkg::*;

   typedef struct packed {
      logic [1:0]   action;
      logic [159:0] data;
   } req_word_type;

   typedef struct packed {
      logic [17:0] noise;
      logic        is_noise;
   } noise_word_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [23:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   gradient_noise_3d uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // predictor state: own copies of the tables
   logic [7:0]  perm_copy [256];
   logic [47:0] grad_copy [256];

   req_word_type   pending_words [$];
   noise_word_type expected_noise [$];
   int             fail_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             hold_cycles = 0;
   bit             stim_done = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // floor(v / 2^s + half when rnd)
   function automatic longint shift_round(longint v, int s, bit rnd);
      if (rnd) v = v + (longint'(1) <<< (s - 1));
      return v >>> s;
   endfunction

   function automatic longint ease(longint f);
      longint t2;
      t2 = shift_round(f * f, 16, 1);
      return shift_round(t2 * (3 * 65536 - 2 * f), 16, 1);
   endfunction

   function automatic longint mix(longint s, longint a, longint b);
      return a + shift_round(s * (b - a), 16, 1);
   endfunction

   function automatic longint corner_dot(longint idx, longint rx, longint ry, longint rz);
      logic [47:0] g;
      g = grad_copy[idx[7:0]];
      return shift_round(longint'($signed(g[15:0])) * rx + longint'($signed(g[31:16])) * ry
                         + longint'($signed(g[47:32])) * rz, 14, 1);
   endfunction

   function automatic longint noise_at(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      longint cx, cy, cz, rx0, ry0, rz0, rx1, ry1, rz1, sx, sy, sz;
      longint i, j, b00, b10, b01, b11, a, b, c, d;
      cx = longint'($signed(px)) >>> 16;
      cy = longint'($signed(py)) >>> 16;
      cz = longint'($signed(pz)) >>> 16;
      rx0 = px[15:0]; ry0 = py[15:0]; rz0 = pz[15:0];
      rx1 = rx0 - 65536; ry1 = ry0 - 65536; rz1 = rz0 - 65536;
      i = perm_copy[cx[7:0]];
      j = perm_copy[8'(cx + 1)];
      b00 = perm_copy[8'(i + cy)];
      b10 = perm_copy[8'(j + cy)];
      b01 = perm_copy[8'(i + cy + 1)];
      b11 = perm_copy[8'(j + cy + 1)];
      sx = ease(rx0); sy = ease(ry0); sz = ease(rz0);
      a = mix(sx, corner_dot(b00 + cz, rx0, ry0, rz0), corner_dot(b10 + cz, rx1, ry0, rz0));
      b = mix(sx, corner_dot(b01 + cz, rx0, ry1, rz0), corner_dot(b11 + cz, rx1, ry1, rz0));
      c = mix(sy, a, b);
      a = mix(sx, corner_dot(b00 + cz + 1, rx0, ry0, rz1),
              corner_dot(b10 + cz + 1, rx1, ry0, rz1));
      b = mix(sx, corner_dot(b01 + cz + 1, rx0, ry1, rz1),
              corner_dot(b11 + cz + 1, rx1, ry1, rz1));
      d = mix(sy, a, b);
      return mix(sz, c, d);
   endfunction

   // update tables and queue the expected answer for one accepted word
   task automatic predict_word(req_word_type w);
      noise_word_type e;
      longint r;
      e = '0;
      if (w.action == ACT_LOAD_PERM) begin
         perm_copy[w.data[7:0]] = w.data[15:8];
      end else if (w.action == ACT_LOAD_GRAD) begin
         grad_copy[w.data[7:0]] = w.data[63:16];
      end else if (w.action == ACT_EVAL) begin
         r = noise_at(w.data[95:64], w.data[127:96], w.data[159:128]);
         if (r > NOISE_MAX) r = NOISE_MAX;
         if (r < NOISE_MIN) r = NOISE_MIN;
         e.noise = r[17:0];
         e.is_noise = 1;
      end
      expected_noise.push_back(e);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic req_word_type make_word(logic [1:0] act, logic [7:0] idx,
                                              logic [7:0] pv, logic [47:0] g,
                                              logic [95:0] p);
      req_word_type w;
      w.action = act;
      w.data = {p, g, pv, idx};
      return w;
   endfunction

   function automatic logic [15:0] rand_grad();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 16'(-16384);
      if (k == 1) return 16'd16384;
      if (k == 2) return 16'($urandom);   // may fall outside the range, used as given
      return 16'($urandom_range(0, 32768) - 16384);
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h8000_0000 + $urandom_range(0, 65535);
         2: return 32'h7fff_0000 + $urandom_range(0, 65535);
         3: return 32'($signed($urandom_range(0, 1048575)) - 524288);
         default: return 32'($urandom_range(0, 20 * 65536)) - 32'(10 * 65536);
      endcase
   endfunction

   function automatic req_word_type rand_word();
      logic [95:0] p;
      p = {rand_coord(), rand_coord(), rand_coord()};
      case ($urandom_range(0, 9))
         0: return make_word(ACT_LOAD_PERM, 8'($urandom), 8'($urandom), 48'($urandom), p);
         1: return make_word(ACT_LOAD_GRAD, 8'($urandom), 8'($urandom),
                             {rand_grad(), rand_grad(), rand_grad()}, p);
         2: return make_word(ACT_UNUSED, 8'($urandom), 8'($urandom), 48'($urandom), p);
         default: return make_word(ACT_EVAL, 8'($urandom), 8'($urandom), 48'($urandom), p);
      endcase
   endfunction

   // driver: offers the head of the queue, respecting the idle percentage
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_words.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
            req_word_type w;
            w = pending_words.pop_front();
            predict_word(w);
            req_tvalid <= 1;
            req_tuser <= w.action;
            req_tdata <= w.data;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // ready for responses; a long hold-off overrides the random stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(1, 100) > recv_stall_pct);
      end
   end

   // monitor: compare each response word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_noise.size() == 0) begin
            report_mismatch("unexpected word", 32'(rsp_tdata), 32'd0);
         end else begin
            noise_word_type e;
            e = expected_noise.pop_front();
            if (rsp_tdata !== {6'd0, e.noise})
               report_mismatch("noise_value", 32'(rsp_tdata), {14'd0, e.noise});
            if (rsp_tuser[0] !== e.is_noise)
               report_mismatch("is_noise", 32'(rsp_tuser), 32'(e.is_noise));
         end
      end
   end

   task automatic drain();
      wait (pending_words.size() == 0);
      while (req_tvalid || expected_noise.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: fill both tables completely, then overwrite some entries with extremes
      for (int k = 0; k < 256; k++) begin
         pending_words.push_back(make_word(ACT_LOAD_PERM, 8'(k), 8'($urandom),
                                           48'($urandom), 96'($urandom)));
         pending_words.push_back(make_word(ACT_LOAD_GRAD, 8'(k), 8'($urandom),
                                           {rand_grad(), rand_grad(), rand_grad()}, 96'd0));
      end
      pending_words.push_back(make_word(ACT_LOAD_PERM, 8'hff, 8'hff, 48'hffff_ffff_ffff, '1));
      pending_words.push_back(make_word(ACT_LOAD_GRAD, 8'h00, 8'h00,
                                        {16'd16384, 16'(-16384), 16'h7fff}, '0));
      pending_words.push_back(make_word(ACT_LOAD_GRAD, 8'h01, 8'h00,
                                        {16'h8000, 16'd16384, 16'(-16384)}, '0));
      // evaluation corner cases: zero, max, min, negative and cell wrap
      pending_words.push_back(make_word(ACT_EVAL, 8'd0, 8'd0, 48'd0, 96'd0));
      pending_words.push_back(make_word(ACT_EVAL, 8'd0, 8'd0, 48'd0, {3{32'h7fff_ffff}}));
      pending_words.push_back(make_word(ACT_EVAL, 8'd0, 8'd0, 48'd0, {3{32'h8000_0000}}));
      pending_words.push_back(make_word(ACT_EVAL, 8'd0, 8'd0, 48'd0, {3{32'hffff_ffff}}));
      pending_words.push_back(make_word(ACT_EVAL, 8'd0, 8'd0, 48'd0, {3{32'h00ff_8000}}));
      pending_words.push_back(make_word(ACT_EVAL, 8'd0, 8'd0, 48'd0, {3{32'hefff_0001}}));
      pending_words.push_back(make_word(ACT_EVAL, 8'd0, 8'd0, 48'd0,
                                        {32'h0001_0000, 32'hffff_0000, 32'h0000_ffff}));
      pending_words.push_back(make_word(ACT_UNUSED, 8'hff, 8'hff, '1, '1));
      for (int k = 0; k < 6; k++)
         pending_words.push_back(make_word(ACT_EVAL, 8'd0, 8'd0, 48'd0,
                                           {3{32'h3000_8000 * k}}));
      drain();

      // random phases with different idling
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? 70 : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? 70 : 0;
         if (ph == 3) begin
            send_idle_pct = 28;
            recv_stall_pct = 28;
         end
         for (int k = 0; k < 25; k++) pending_words.push_back(rand_word());
         if (ph == 0) hold_cycles = 200;   // receiver holds off while words keep coming
         drain();
      end
      repeat (30) @(posedge clock);

      if (fail_count == 0)
         $display("gradient_noise_3d: match");
      else
         $display("gradient_noise_3d: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("gradient_noise_3d: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
design/gn3d_pkg.sv
design/gn3d_ram.sv
design/gradient_noise_3d.sv
tb/testbench.sv
